[rtl/bounded_set_store_assert.svh]
// Assertion macros of the bounded set store RTL.
`ifndef BOUNDED_SET_STORE_ASSERT_SVH
`define BOUNDED_SET_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_set_store: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_set_store: next-cycle check failed");

`endif

[rtl/bss_pkg.sv]
// Shared constants and types of the bounded set store.
package bss_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] last_val;
  } token_t;

  // Broadcast write to the row of cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] data;
  } wr_t;

endpackage

[rtl/bounded_set_store.sv]
// Top level of the bounded set store: command handshake, cell row and commit.
// Each command runs a search token down a row of sixteen cells, one cell per
// cycle. The outcome is latched in the next cycle and any insert or delete is
// committed in the cycle after that, unless the output register still holds an
// untaken result, which stalls the commit; the result is registered at the
// commit. The next command is taken in the cycle after the commit. This
// holds even while the previous result still waits in the output register.
// The capacity register may be written at any idle time; values above
// sixteen act as sixteen. No clearing pass follows reset.
module bounded_set_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,    // capacity_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,        // command[1:0], value[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata         // found[0], position[5:1],
                                      // count_after[10:6], status[12:11], zero pad
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [4:0]                      cap_limit;
  logic [bss_pkg::CNT_W-1:0]       count;
  logic [bss_pkg::CNT_W-1:0]       count_next;
  logic [bss_pkg::CNT_W-1:0]       cap;
  logic [1:0]                      cmd;
  logic                            hit;
  logic [bss_pkg::IDX_W-1:0]       hit_pos;
  logic [bss_pkg::VAL_W-1:0]       last_val;
  logic [bss_pkg::VAL_W-1:0]       key;
  logic                            s_xfer;
  logic                            commit;
  logic                            do_insert;
  logic                            do_delete;
  logic [1:0]                      status;
  logic [bss_pkg::CNT_W-1:0]       position;
  bss_pkg::token_t                 chain [bss_pkg::DEPTH+1];
  bss_pkg::wr_t                    wr;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign commit   = (state == S_COMMIT) && (!m_tvalid || m_tready);

  assign cap = (cap_limit > 5'(bss_pkg::DEPTH)) ? bss_pkg::CNT_W'(bss_pkg::DEPTH) : cap_limit;

  // Launch the token into the first cell on the input transfer.
  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = s_xfer;
    chain[0].key      = s_tdata[33:2];
  end

  for (genvar i = 0; i < bss_pkg::DEPTH; i++) begin : g_cell
    bss_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (bss_pkg::IDX_W'(i)),
      .count   (count),
      .tok_in  (chain[i]),
      .wr      (wr),
      .tok_out (chain[i+1])
    );
  end

  assign do_insert = (cmd == bss_pkg::CMD_INSERT) && (count < cap) && !hit;
  assign do_delete = (cmd == bss_pkg::CMD_DELETE) && hit;

  always_comb begin
    wr.en   = commit && (do_insert || do_delete);
    wr.idx  = do_delete ? hit_pos : count[bss_pkg::IDX_W-1:0];
    wr.data = do_delete ? last_val : key;
  end

  always_comb begin
    status = bss_pkg::ST_OK;
    if ((cmd == bss_pkg::CMD_INSERT) && (count >= cap)) begin
      status = bss_pkg::ST_FULL;
    end else if ((cmd == bss_pkg::CMD_DELETE) && !hit) begin
      status = bss_pkg::ST_ABSENT;
    end
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + bss_pkg::CNT_W'(1);
    end else if (do_delete) begin
      count_next = count - bss_pkg::CNT_W'(1);
    end
  end

  assign position = hit ? {1'b0, hit_pos} : count;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_xfer) state_next = S_SEARCH;
      S_SEARCH: if (chain[bss_pkg::DEPTH].valid) state_next = S_COMMIT;
      S_COMMIT: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap_limit <= 5'(bss_pkg::DEPTH);
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      if (commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the command and the search outcome until commit, and register the result at commit.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      cmd <= s_tdata[1:0];
      key <= s_tdata[33:2];
    end
    if (chain[bss_pkg::DEPTH].valid) begin
      hit      <= chain[bss_pkg::DEPTH].hit;
      hit_pos  <= chain[bss_pkg::DEPTH].pos;
      last_val <= chain[bss_pkg::DEPTH].last_val;
    end
    if (commit) begin
      m_tdata <= {3'b000, status, count_next, position, hit};
    end
  end

`include "bounded_set_store_assert.svh"

  `BSS_ASSERT_NOW(a_count_bound, 1'b1, count <= bss_pkg::CNT_W'(bss_pkg::DEPTH))
  `BSS_ASSERT_NOW(a_token_in_search, chain[bss_pkg::DEPTH].valid, state == S_SEARCH)
  `BSS_ASSERT_NEXT(a_count_only_on_commit, !commit, $stable(count))
  `BSS_ASSERT_NOW(a_hit_below_count, commit && hit, {1'b0, hit_pos} < count)

endmodule

[rtl/bss_cell.sv]
// One storage cell of the set: holds an entry and compares the passing token.
module bss_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bss_pkg::IDX_W-1:0] idx,
  input  logic [bss_pkg::CNT_W-1:0] count,
  input  bss_pkg::token_t           tok_in,
  input  bss_pkg::wr_t              wr,
  output bss_pkg::token_t           tok_out
);

  logic [bss_pkg::VAL_W-1:0] entry;
  logic                      occupied;
  bss_pkg::token_t           tok_next;

  assign occupied = {1'b0, idx} < count;

  always_comb begin
    tok_next = tok_in;
    if (occupied && !tok_in.hit && (entry == tok_in.key)) begin
      tok_next.hit = 1'b1;
      tok_next.pos = idx;
    end
    // grab the last occupied entry for a later delete
    if (({1'b0, idx} + bss_pkg::CNT_W'(1)) == count) begin
      tok_next.last_val = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == idx)) begin
      entry <= wr.data;
    end
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for the bounded set store: directed, random and back-pressure tests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          CLK_HALF    = 4;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SINK_HOLD   = 300;
  localparam int          SETTLE      = 40;
  localparam int          POOL_SIZE   = 24;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

  typedef struct packed {
    logic                      found;
    logic [bss_pkg::CNT_W-1:0] position;
    logic [bss_pkg::CNT_W-1:0] count_after;
    logic [1:0]                status;
  } set_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = 40'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Shadow copy of the store, kept in step with accepted commands
  logic [bss_pkg::VAL_W-1:0] set_vals [bss_pkg::DEPTH];
  int unsigned      set_count = 0;
  logic [4:0]       set_cap = 5'd16;

  set_reply_t  reply_q [$];
  set_reply_t  due_reply;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  bit          src_offered = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] val_pool [POOL_SIZE];

  bounded_set_store i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Search the shadow store and apply the command to it
  function automatic set_reply_t predict_cmd(logic [1:0] cmd, logic [bss_pkg::VAL_W-1:0] val);
    set_reply_t  r;
    int unsigned eff_cap;
    int unsigned pos;
    logic        hit;
    eff_cap = (set_cap > bss_pkg::DEPTH) ? bss_pkg::DEPTH : set_cap;
    pos = set_count;
    hit = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      if (!hit && set_vals[i] == val) begin
        hit = 1'b1;
        pos = i;
      end
    end
    r.status = bss_pkg::ST_OK;
    case (cmd)
      bss_pkg::CMD_INSERT: begin
        if (set_count >= eff_cap) begin
          r.status = bss_pkg::ST_FULL;
        end else if (!hit) begin
          set_vals[set_count] = val;
          set_count++;
        end
      end
      bss_pkg::CMD_DELETE: begin
        if (!hit) begin
          r.status = bss_pkg::ST_ABSENT;
        end else begin
          set_vals[pos] = set_vals[set_count-1];
          set_count--;
        end
      end
      default: ;
    endcase
    r.found = hit;
    r.position = pos[bss_pkg::CNT_W-1:0];
    r.count_after = set_count[bss_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $error("result with no command pending: tdata=%h", m_tdata);
        err_count++;
      end else begin
        due_reply = reply_q.pop_front();
        check_field("found", due_reply.found, m_tdata[0]);
        check_field("position", due_reply.position, m_tdata[5:1]);
        check_field("count_after", due_reply.count_after, m_tdata[10:6]);
        check_field("status", due_reply.status, m_tdata[12:11]);
      end
    end
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      m_tready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input logic [bss_pkg::VAL_W-1:0] val);
    int unsigned gap;
    if (!no_idle && $urandom_range(99) < 19) begin
      gap = $urandom_range(24, 1);
      if (src_offered) s_tvalid <= 1'b0;
      src_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, val, cmd};
    src_offered = 1'b1;
    do @(posedge clk); while (!s_tready);
    reply_q.push_back(predict_cmd(cmd, val));
  endtask

  // Withdraw the offer and hold until every result has been taken
  task automatic wait_replies();
    if (src_offered) s_tvalid <= 1'b0;
    src_offered = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    wait_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_cap = cap;
  endtask

  function automatic logic [1:0] pick_cmd(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < insert_pct) return bss_pkg::CMD_INSERT;
    if (r < insert_pct + 30) return bss_pkg::CMD_DELETE;
    if (r < 95) return bss_pkg::CMD_LOOKUP;
    return CMD_UNUSED;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) == 0) return $urandom;
    return val_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) val_pool[i] = $urandom;
    if ($urandom_range(1)) begin
      val_pool[0] = VAL_MIN;
      val_pool[1] = VAL_MAX;
      val_pool[2] = 32'd0;
      val_pool[3] = 32'hffff_ffff;
    end
  endtask

  task automatic test_directed_ops();
    send_cmd(bss_pkg::CMD_LOOKUP, 32'd0);          // empty store
    send_cmd(bss_pkg::CMD_DELETE, 32'd0);          // absent on empty
    send_cmd(bss_pkg::CMD_INSERT, VAL_MIN);
    send_cmd(bss_pkg::CMD_INSERT, VAL_MAX);
    send_cmd(bss_pkg::CMD_INSERT, 32'd0);
    send_cmd(bss_pkg::CMD_INSERT, 32'hffff_ffff);
    send_cmd(bss_pkg::CMD_INSERT, VAL_MAX);        // already present
    send_cmd(bss_pkg::CMD_LOOKUP, 32'hffff_ffff);
    send_cmd(CMD_UNUSED, VAL_MAX);                 // acts as lookup
    send_cmd(bss_pkg::CMD_LOOKUP, 32'd1);
    send_cmd(bss_pkg::CMD_DELETE, VAL_MIN);        // last entry moves to the front
    send_cmd(bss_pkg::CMD_LOOKUP, 32'hffff_ffff);
    send_cmd(bss_pkg::CMD_DELETE, 32'hffff_ffff);
  endtask

  task automatic test_directed_capacity();
    write_capacity(5'd2);
    send_cmd(bss_pkg::CMD_INSERT, 32'd5);          // full
    send_cmd(bss_pkg::CMD_INSERT, 32'd0);          // full even though present
    write_capacity(5'd0);
    send_cmd(bss_pkg::CMD_INSERT, 32'd7);
    send_cmd(bss_pkg::CMD_DELETE, VAL_MAX);        // delete still works below count
    write_capacity(5'd31);                         // saturates to depth
    send_cmd(bss_pkg::CMD_INSERT, 32'd7);
    send_cmd(bss_pkg::CMD_INSERT, 32'h5555_5555);
    send_cmd(bss_pkg::CMD_INSERT, 32'haaaa_aaaa);
    write_capacity(5'd1);
    send_cmd(bss_pkg::CMD_INSERT, 32'd9);
    send_cmd(bss_pkg::CMD_LOOKUP, 32'haaaa_aaaa);
  endtask

  task automatic test_random_phases();
    logic [4:0]  caps [8] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd8, 5'd20, 5'd3, 5'd16};
    int unsigned ins_pct [8] = '{45, 60, 45, 40, 50, 60, 40, 55};
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      refill_pool();
      no_idle = (p == 0);
      for (int n = 0; n < 80; n++) send_cmd(pick_cmd(ins_pct[p]), pick_value());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_back_pressure();
    write_capacity(5'd16);
    refill_pool();
    hold_req = 1'b1;
    for (int n = 0; n < 20; n++) send_cmd(pick_cmd(50), pick_value());
    // sender pauses until the store has drained
    wait_replies();
    for (int n = 0; n < 10; n++) send_cmd(pick_cmd(50), pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_directed_capacity();
    test_random_phases();
    test_back_pressure();
    wait_replies();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && reply_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
